// File: rtl/core/adcp_pkg.sv
// Shared types, character codes and helpers for the ASCII decimal command parser.
// No dependencies; used by adcp_step and ascii_decimal_command_parser_core.
package adcp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ACC_W   = 19;  // four folded digits, each -48..207
  localparam int unsigned WIN_W   = 24;  // last three region bytes
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned VALUE_W = 26;
  localparam int unsigned DIGIT_W = 9;

  localparam logic [BYTE_W-1:0] CH_EQUALS = 8'h3D;  // '='
  localparam logic [BYTE_W-1:0] CH_END    = 8'h40;  // '@'
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;  // '-'

  localparam logic [CNT_W-1:0] CNT_FOLD_MIN = 4'd3;
  localparam logic [CNT_W-1:0] LEN_MIN      = 4'd4;
  localparam logic [CNT_W-1:0] LEN_MAX      = 4'd7;
  localparam logic [CNT_W-1:0] CNT_MAX      = 4'd8;

  localparam logic signed [DIGIT_W-1:0] DIGIT_BASE = 9'sd48;

  // Per-message parse state.
  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic [WIN_W-1:0]        window;
    logic [CNT_W-1:0]        count;
    logic                    neg;
  } adcp_state_t;

  // Result of one byte: fire marks an end-of-message byte.
  typedef struct packed {
    logic                      fire;
    logic signed [VALUE_W-1:0] value;
    logic                      len_ok;
  } adcp_result_t;

  // Byte minus '0', no range check.
  function automatic logic signed [DIGIT_W-1:0] digit_of(input logic [BYTE_W-1:0] b);
    return $signed({1'b0, b}) - DIGIT_BASE;
  endfunction

endpackage

// File: rtl/core/adcp_step.sv
// Next-state and result logic for one received byte of the command parser.
// Depends on adcp_pkg.
module adcp_step (
  input  logic [adcp_pkg::BYTE_W-1:0] rx_byte,
  input  adcp_pkg::adcp_state_t       state_cur,
  output adcp_pkg::adcp_state_t       state_nxt,
  output adcp_pkg::adcp_result_t      result
);

  logic signed [adcp_pkg::DIGIT_W-1:0] d_head;
  logic signed [adcp_pkg::DIGIT_W-1:0] d_tenths;
  logic signed [adcp_pkg::DIGIT_W-1:0] d_hund;
  logic signed [adcp_pkg::ACC_W-1:0]   acc_fold;
  logic signed [adcp_pkg::VALUE_W-1:0] mag;
  logic                                len_ok;
  adcp_pkg::adcp_state_t               cleared;

  assign d_head   = adcp_pkg::digit_of(state_cur.window[23:16]);
  assign d_tenths = adcp_pkg::digit_of(state_cur.window[15:8]);
  assign d_hund   = adcp_pkg::digit_of(state_cur.window[7:0]);

  // acc*10 + oldest window digit
  assign acc_fold = state_cur.acc * 19'sd10
                  + adcp_pkg::ACC_W'(d_head);

  // Constant multiplies only: acc*100 + tenths*10 + hundredths.
  assign mag = adcp_pkg::VALUE_W'(state_cur.acc) * 26'sd100
             + adcp_pkg::VALUE_W'(d_tenths) * 26'sd10
             + adcp_pkg::VALUE_W'(d_hund);

  assign len_ok = (state_cur.count >= adcp_pkg::LEN_MIN) &&
                  (state_cur.count <= adcp_pkg::LEN_MAX);

  assign cleared = '{acc: '0, window: '0, count: '0, neg: 1'b0};

  always_comb begin
    state_nxt     = state_cur;
    result.fire   = 1'b0;
    result.len_ok = 1'b0;
    result.value  = '0;
    if (rx_byte == adcp_pkg::CH_END) begin
      result.fire   = 1'b1;
      result.len_ok = len_ok;
      if (len_ok) begin
        result.value = state_cur.neg ? -mag : mag;
      end
      state_nxt = cleared;
    end else if (rx_byte == adcp_pkg::CH_EQUALS) begin
      state_nxt = cleared;
    end else if (rx_byte == adcp_pkg::CH_MINUS && state_cur.count == '0 && !state_cur.neg) begin
      state_nxt.neg = 1'b1;
    end else begin
      if (state_cur.count >= adcp_pkg::CNT_FOLD_MIN && state_cur.count < adcp_pkg::LEN_MAX) begin
        state_nxt.acc = acc_fold;
      end
      state_nxt.window = {state_cur.window[15:0], rx_byte};
      if (state_cur.count < adcp_pkg::CNT_MAX) begin
        state_nxt.count = state_cur.count + 4'd1;
      end
    end
  end

endmodule

// File: rtl/core/ascii_decimal_command_parser_core.sv
// Top level of the ASCII decimal command parser: stream ports, input and result registers.
// Depends on adcp_pkg and adcp_step.
//
// Parses a byte stream of messages "name=value@" and emits, for each '@', one
// request holding the value in signed hundredths. A message starts after reset
// or the previous '@'; each '=' restarts the value region. A leading '-' in the
// region makes the value negative. A region of 4 to 7 characters is valid: the
// last two are tenths and hundredths, the third-last is the point (not checked),
// the rest are integer digits; every digit is byte minus '0' with no check.
// Other lengths give value 0 with length_ok low. Bytes other than '@' produce no
// output. Throughput is one byte per clock while no '@' stalls: each byte is held
// in the input register, and the parse state and the result register are updated
// as it leaves it, so a result is valid in the result register once its '@' has
// left the input register. The only stall source is the result register: a '@'
// waits in the input register while an earlier result is not yet taken; all other
// bytes pass regardless.
module ascii_decimal_command_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [25:0] value_hundredths, [31:26] zero
  output logic        out_tuser   // [0] length_ok
);

  // input register
  logic                          s1_valid_r;
  logic                          s1_valid_nxt;
  logic [adcp_pkg::BYTE_W-1:0]   s1_byte_r;

  // parse state
  adcp_pkg::adcp_state_t         state_r;
  adcp_pkg::adcp_state_t         state_nxt;
  adcp_pkg::adcp_state_t         step_state;
  adcp_pkg::adcp_result_t        step_res;

  // result register
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic signed [adcp_pkg::VALUE_W-1:0] out_value_r;
  logic                          out_ok_r;

  logic out_free;
  logic s1_go;
  logic in_acc;
  logic res_load;

  adcp_step u_step (
    .rx_byte   (s1_byte_r),
    .state_cur (state_r),
    .state_nxt (step_state),
    .result    (step_res)
  );

  assign out_free = !out_valid_r || out_tready;
  // Non-terminating bytes never need the result register.
  assign s1_go    = s1_valid_r && (!step_res.fire || out_free);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_acc   = in_tvalid && in_tready;
  assign res_load = s1_go && step_res.fire;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
  assign state_nxt     = s1_go ? step_state : state_r;
  assign out_valid_nxt = res_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{acc: '0, window: '0, count: '0, neg: 1'b0};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
    end
    if (res_load) begin
      out_value_r <= step_res.value;
      out_ok_r    <= step_res.len_ok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_value_r};
  assign out_tuser  = out_ok_r;

`ifndef SYNTHESIS
  // An invalid length always reports zero.
  a_bad_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[25:0] == '0))
    else $error("nonzero value with length_ok low");

  // Character count saturates.
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.count <= adcp_pkg::CNT_MAX)
    else $error("region count beyond saturation");

  // A consumed '@' or '=' clears the region.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && (s1_byte_r == adcp_pkg::CH_END || s1_byte_r == adcp_pkg::CH_EQUALS))
      |=> (state_r.count == '0 && state_r.acc == '0 && !state_r.neg))
    else $error("region not cleared after delimiter");

  // An empty region holds no data; nothing is folded before three characters are held.
  a_empty_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.count == '0) |-> (state_r.acc == '0 && state_r.window == '0))
    else $error("empty region holds data");
`endif

endmodule
